@@ sv/zpc_pkg.sv @@
package zpc_pkg;

  localparam int MAX_HALF_X = 3;
  localparam int MAX_HALF_Y = 3;
  localparam int MAX_WIDTH  = 1024;

  localparam int PIX_W   = 16;
  localparam int COEFF_W = 16;
  localparam int PROD_W  = 32;
  localparam int ACC_W   = 48;
  localparam int FUNC_W  = 2;
  localparam int KPOS_W  = 3;
  localparam int CFG_W   = 11;
  localparam int CFG_AW  = 2;
  localparam int HALF_W  = 2;
  localparam int ROW_W   = 11;

  localparam logic [ROW_W-1:0] ROW_SAT = 11'd2047;

  localparam int FIFO_DEPTH = 8;

  localparam logic [FUNC_W-1:0] FUNC_LOAD  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_PIXEL = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_FLUSH = 2'd2;

  localparam logic [CFG_AW-1:0] REG_IMAGE_WIDTH = 2'd0;
  localparam logic [CFG_AW-1:0] REG_HALF_X      = 2'd1;
  localparam logic [CFG_AW-1:0] REG_HALF_Y      = 2'd2;

  typedef struct packed {
    logic shift;
    logic coeff_we;
    logic mask_we;
    logic mask;
  } cell_ctrl_t;

endpackage

@@ sv/zpc_cell.sv @@
module zpc_cell (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  zpc_pkg::cell_ctrl_t                    ctrl_i,
  input  logic signed [zpc_pkg::COEFF_W-1:0]     coeff_i,
  input  logic signed [zpc_pkg::PIX_W-1:0]       data_i,
  output logic signed [zpc_pkg::PIX_W-1:0]       data_o,
  output logic signed [zpc_pkg::PROD_W-1:0]      prod_o
);

  logic signed [zpc_pkg::PIX_W-1:0]   win_q;
  logic signed [zpc_pkg::COEFF_W-1:0] coeff_q;
  logic                               mask_q;
  logic signed [zpc_pkg::PROD_W-1:0]  prod_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q   <= '0;
      coeff_q <= '0;
      mask_q  <= 1'b0;
    end else begin
      if (ctrl_i.shift) begin
        win_q <= data_i;
      end
      if (ctrl_i.coeff_we) begin
        coeff_q <= coeff_i;
      end
      if (ctrl_i.mask_we) begin
        mask_q <= ctrl_i.mask;
      end
    end
  end

  // Positions outside the image contribute nothing to the sum.
  always_ff @(posedge clk_i) begin
    if (mask_q) begin
      prod_q <= win_q * coeff_q;
    end else begin
      prod_q <= '0;
    end
  end

  assign data_o = win_q;
  assign prod_o = prod_q;

endmodule

@@ sv/zpc_line.sv @@
module zpc_line #(
  parameter int MAX_HALF_X = zpc_pkg::MAX_HALF_X,
  parameter int MAX_HALF_Y = zpc_pkg::MAX_HALF_Y,
  parameter int MAX_WIDTH  = zpc_pkg::MAX_WIDTH
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 wr_en_i,
  input  logic signed [zpc_pkg::PIX_W-1:0]     wr_data_i,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]       weff_i,
  input  logic [$clog2(2*MAX_HALF_X+3)-1:0]    extra_i,
  output logic signed [zpc_pkg::PIX_W-1:0]     head_o [2*MAX_HALF_Y+1]
);

  localparam int KROWS    = 2 * MAX_HALF_Y + 1;
  localparam int KCOLS    = 2 * MAX_HALF_X + 1;
  localparam int LAST_OFF = (KROWS - 1) * MAX_WIDTH + KCOLS - 1;
  localparam int RING_AW  = $clog2(LAST_OFF + 2);
  localparam int RING     = 1 << RING_AW;

  logic [RING_AW-1:0] wp_q, wp_d;
  logic [RING_AW-1:0] fill_q, fill_d;
  logic [RING_AW-1:0] base;

  // The fill count stands in for clearing the ring: a sample older than
  // everything written since reset reads as zero.
  always_comb begin
    wp_d   = wp_q;
    fill_d = fill_q;
    if (wr_en_i) begin
      wp_d = wp_q + RING_AW'(1);
      if (fill_q != '1) begin
        fill_d = fill_q + RING_AW'(1);
      end
    end
    base = wp_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q   <= '0;
      fill_q <= '0;
    end else begin
      wp_q   <= wp_d;
      fill_q <= fill_d;
    end
  end

  assign head_o[0] = wr_data_i;

  // Each kernel row above the current one reads its own copy of the ring,
  // prefetching the sample that the next transfer will need.
  for (genvar k = 1; k < KROWS; k++) begin : g_tap
    logic signed [zpc_pkg::PIX_W-1:0] ring_q [RING];
    logic signed [zpc_pkg::PIX_W-1:0] rd_q;
    logic signed [zpc_pkg::PIX_W-1:0] bdat_q;
    logic                             byp_q;
    logic                             vld_q;
    logic [RING_AW-1:0]               off;
    logic [RING_AW-1:0]               rd_addr;

    always_comb begin
      off     = RING_AW'(RING_AW'(k) * RING_AW'(weff_i)) + RING_AW'(extra_i);
      rd_addr = base - off;
    end

    always_ff @(posedge clk_i) begin
      if (wr_en_i) begin
        ring_q[wp_q] <= wr_data_i;
      end
      rd_q   <= ring_q[rd_addr];
      bdat_q <= wr_data_i;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        byp_q <= 1'b0;
        vld_q <= 1'b0;
      end else begin
        byp_q <= wr_en_i && (off == RING_AW'(1));
        vld_q <= (off <= fill_d);
      end
    end

    assign head_o[k] = !vld_q ? '0 : (byp_q ? bdat_q : rd_q);
  end

endmodule

@@ sv/zpc_fifo.sv @@
module zpc_fifo #(
  parameter int DEPTH = zpc_pkg::FIFO_DEPTH,
  parameter int WIDTH = zpc_pkg::ACC_W + 1
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  input  logic [WIDTH-1:0]             data_i,
  input  logic                         pop_i,
  output logic [WIDTH-1:0]             data_o,
  output logic [$clog2(DEPTH+1)-1:0]   count_o
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_q, rd_q;
  logic [CW-1:0]    cnt_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + AW'(1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + AW'(1);
      end
      cnt_q <= cnt_q + CW'(push_i) - CW'(pop_i);
    end
  end

  assign data_o  = mem_q[rd_q];
  assign count_o = cnt_q;

endmodule

@@ sv/zero_padded_2d_convolution.sv @@
// True 2D convolution with zero padding over a raster pixel stream. Coefficients are loaded
// with load transfers, pixels follow in raster order, and after the frame half_y*width+half_x
// flush transfers drain the remaining results; the final one carries last. The block takes
// one transfer per cycle unless stalled; a result passes through the product and row-sum
// registers into an eight-entry output queue, and input stalls when the queue and results in
// flight fill it. The window is a grid of multiply cells that shift samples along each kernel
// row; every kernel row above the current one is fed by its own ring copy of recent samples,
// one read port per row. Writing image_width stalls input while the window columns reload
// from the rings at the new row pitch. The rings need no clearing pass after reset.
module zero_padded_2d_convolution #(
  parameter int MAX_HALF_X = zpc_pkg::MAX_HALF_X,
  parameter int MAX_HALF_Y = zpc_pkg::MAX_HALF_Y,
  parameter int MAX_WIDTH  = zpc_pkg::MAX_WIDTH
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [zpc_pkg::CFG_AW-1:0]           cfg_addr_i,
  input  logic [zpc_pkg::CFG_W-1:0]            cfg_wdata_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [zpc_pkg::FUNC_W-1:0]           func_i,
  input  logic signed [zpc_pkg::PIX_W-1:0]     pixel_i,
  input  logic [zpc_pkg::KPOS_W-1:0]           coeff_row_i,
  input  logic [zpc_pkg::KPOS_W-1:0]           coeff_col_i,
  input  logic signed [zpc_pkg::COEFF_W-1:0]   coeff_value_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [zpc_pkg::ACC_W-1:0]     out_value_o,
  output logic                                 last_o
);

  localparam int KROWS = 2 * MAX_HALF_Y + 1;
  localparam int KCOLS = 2 * MAX_HALF_X + 1;
  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int CW1   = CW + 1;
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int FLW   = $clog2(3 * MAX_WIDTH + 4);
  localparam int TCW   = WW + 2;
  localparam int NW    = $clog2(MAX_HALF_X + 2);
  localparam int RFW   = $clog2(KCOLS + 2);
  localparam int OCW   = $clog2(zpc_pkg::FIFO_DEPTH + 4);
  localparam int FCW   = $clog2(zpc_pkg::FIFO_DEPTH + 1);
  localparam int ROW_W = zpc_pkg::ROW_W;
  localparam int ACC_W = zpc_pkg::ACC_W;

  logic [zpc_pkg::CFG_W-1:0]  width_q;
  logic [zpc_pkg::HALF_W-1:0] hx_q, hy_q;
  logic [CW-1:0]              col_q, col_d;
  logic [ROW_W-1:0]           row_q, row_d;
  logic [FLW-1:0]             flush_q, flush_d, flush_n;
  logic [RFW-1:0]             rf_q, rf_d;
  logic                       sh_q;

  logic [WW-1:0]              weff;
  logic [zpc_pkg::HALF_W-1:0] hx_eff, hy_eff;
  logic [FLW-1:0]             delay;
  logic                       accept, is_load, is_pix, is_fl;
  logic                       wr_en, emit, fin, delay_zero;
  logic signed [zpc_pkg::PIX_W-1:0] wr_data;
  logic [RFW-1:0]             extra;

  logic signed [TCW-1:0]      tc;
  logic [NW-1:0]              nwrap;

  logic signed [zpc_pkg::PIX_W-1:0]  head [KROWS];
  logic signed [zpc_pkg::PIX_W-1:0]  win  [KROWS][KCOLS];
  logic signed [zpc_pkg::PIX_W-1:0]  din  [KROWS][KCOLS];
  logic signed [zpc_pkg::PROD_W-1:0] prod [KROWS][KCOLS];
  zpc_pkg::cell_ctrl_t               ctrl [KROWS][KCOLS];

  logic signed [ACC_W-1:0]    rsum_d [KROWS];
  logic signed [ACC_W-1:0]    rsum_q [KROWS];
  logic signed [ACC_W-1:0]    total;

  logic                       v1_q, v2_q, v3_q;
  logic                       last1_q, last2_q, last3_q;
  logic [FCW-1:0]             fifo_cnt;
  logic [OCW-1:0]             occ;
  logic [ACC_W:0]             fifo_out;

  always_comb begin
    if (width_q == '0) begin
      weff = WW'(1);
    end else if (32'(width_q) > MAX_WIDTH) begin
      weff = WW'(MAX_WIDTH);
    end else begin
      weff = WW'(width_q);
    end
    hx_eff = (32'(hx_q) > MAX_HALF_X) ? zpc_pkg::HALF_W'(MAX_HALF_X) : hx_q;
    hy_eff = (32'(hy_q) > MAX_HALF_Y) ? zpc_pkg::HALF_W'(MAX_HALF_Y) : hy_q;
    delay  = FLW'(FLW'(hy_eff) * FLW'(weff)) + FLW'(hx_eff);
  end

  assign occ        = OCW'(fifo_cnt) + OCW'(v1_q) + OCW'(v2_q) + OCW'(v3_q);
  assign in_ready_o = (rf_q == '0) && (occ < OCW'(zpc_pkg::FIFO_DEPTH));
  assign accept     = in_valid_i && in_ready_o;
  assign is_load    = accept && (func_i == zpc_pkg::FUNC_LOAD);
  assign is_pix     = accept && (func_i == zpc_pkg::FUNC_PIXEL);
  assign is_fl      = accept && (func_i == zpc_pkg::FUNC_FLUSH);
  assign delay_zero = (delay == '0);
  assign wr_en      = is_pix || (is_fl && !delay_zero);
  assign wr_data    = is_pix ? pixel_i : '0;
  assign flush_n    = flush_q + FLW'(1);
  assign fin        = is_fl && !delay_zero && (flush_n >= delay);
  assign extra      = (rf_q >= RFW'(2)) ? rf_q - RFW'(1) : '0;

  // Target column and how many rows back it sits; a narrow image can wrap
  // the column several times.
  always_comb begin
    tc    = $signed(TCW'(col_q)) - $signed(TCW'(hx_eff));
    nwrap = '0;
    for (int j = 0; j < MAX_HALF_X; j++) begin
      if (tc < 0) begin
        tc    = tc + $signed(TCW'(weff));
        nwrap = nwrap + NW'(1);
      end
    end
  end

  assign emit = wr_en && (row_q >= ROW_W'(hy_eff) + ROW_W'(nwrap));

  always_comb begin
    logic signed [TCW-1:0] sc;
    logic                  row_ok, col_ok;
    for (int r = 0; r < KROWS; r++) begin
      for (int c = 0; c < KCOLS; c++) begin
        sc     = tc - $signed(TCW'(c)) + $signed(TCW'(hx_eff));
        row_ok = (r <= 2 * 32'(hy_eff)) && (ROW_W'(nwrap) + ROW_W'(r) <= row_q);
        col_ok = (c <= 2 * 32'(hx_eff)) && (sc >= 0) && (sc < $signed(TCW'(weff)));
        ctrl[r][c].shift    = (r == 0) ? wr_en : (wr_en || sh_q);
        ctrl[r][c].coeff_we = is_load && (32'(coeff_row_i) == r) && (32'(coeff_col_i) == c);
        ctrl[r][c].mask_we  = wr_en;
        ctrl[r][c].mask     = row_ok && col_ok;
        din[r][c]           = (c == 0) ? head[r] : win[r][(c == 0) ? 0 : c - 1];
      end
    end
  end

  always_comb begin
    col_d   = col_q;
    row_d   = row_q;
    flush_d = flush_q;
    if (is_pix || (is_fl && !delay_zero && !fin)) begin
      flush_d = is_pix ? '0 : flush_n;
      if ({1'b0, col_q} + CW1'(1) >= CW1'(weff)) begin
        col_d = '0;
        row_d = (row_q == zpc_pkg::ROW_SAT) ? row_q : row_q + ROW_W'(1);
      end else begin
        col_d = col_q + CW'(1);
      end
    end else if (is_fl) begin
      col_d   = '0;
      row_d   = '0;
      flush_d = '0;
    end
  end

  always_comb begin
    rf_d = rf_q;
    if (cfg_we_i && (cfg_addr_i == zpc_pkg::REG_IMAGE_WIDTH)) begin
      rf_d = RFW'(KCOLS);
    end else if (rf_q != '0) begin
      rf_d = rf_q - RFW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= zpc_pkg::CFG_W'(128);
      hx_q    <= zpc_pkg::HALF_W'(1);
      hy_q    <= zpc_pkg::HALF_W'(1);
      col_q   <= '0;
      row_q   <= '0;
      flush_q <= '0;
      rf_q    <= '0;
      sh_q    <= 1'b0;
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      last1_q <= 1'b0;
      last2_q <= 1'b0;
      last3_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_addr_i)
          zpc_pkg::REG_IMAGE_WIDTH: width_q <= cfg_wdata_i;
          zpc_pkg::REG_HALF_X:      hx_q <= cfg_wdata_i[zpc_pkg::HALF_W-1:0];
          zpc_pkg::REG_HALF_Y:      hy_q <= cfg_wdata_i[zpc_pkg::HALF_W-1:0];
          default: ;
        endcase
      end
      col_q   <= col_d;
      row_q   <= row_d;
      flush_q <= flush_d;
      rf_q    <= rf_d;
      sh_q    <= (rf_q >= RFW'(2));
      v1_q    <= emit;
      last1_q <= fin;
      v2_q    <= v1_q;
      last2_q <= last1_q;
      v3_q    <= v2_q;
      last3_q <= last2_q;
    end
  end

  zpc_line #(
    .MAX_HALF_X (MAX_HALF_X),
    .MAX_HALF_Y (MAX_HALF_Y),
    .MAX_WIDTH  (MAX_WIDTH)
  ) u_line (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (wr_en),
    .wr_data_i (wr_data),
    .weff_i    (weff),
    .extra_i   (extra),
    .head_o    (head)
  );

  for (genvar r = 0; r < KROWS; r++) begin : g_row
    for (genvar c = 0; c < KCOLS; c++) begin : g_col
      zpc_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .ctrl_i  (ctrl[r][c]),
        .coeff_i (coeff_value_i),
        .data_i  (din[r][c]),
        .data_o  (win[r][c]),
        .prod_o  (prod[r][c])
      );
    end
  end

  always_comb begin
    for (int r = 0; r < KROWS; r++) begin
      rsum_d[r] = '0;
      for (int c = 0; c < KCOLS; c++) begin
        rsum_d[r] = rsum_d[r] + ACC_W'(prod[r][c]);
      end
    end
    total = '0;
    for (int r = 0; r < KROWS; r++) begin
      total = total + rsum_q[r];
    end
  end

  always_ff @(posedge clk_i) begin
    rsum_q <= rsum_d;
  end

  zpc_fifo #(
    .DEPTH (zpc_pkg::FIFO_DEPTH),
    .WIDTH (ACC_W + 1)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (v3_q),
    .data_i  ({last3_q, total}),
    .pop_i   (out_valid_o && out_ready_i),
    .data_o  (fifo_out),
    .count_o (fifo_cnt)
  );

  assign out_valid_o = (fifo_cnt != '0);
  assign out_value_o = fifo_out[ACC_W-1:0];
  assign last_o      = fifo_out[ACC_W];

  a_occupancy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ <= OCW'(zpc_pkg::FIFO_DEPTH))
    else $error("results in flight exceed the output queue");

  a_refill_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_we_i && (cfg_addr_i == zpc_pkg::REG_IMAGE_WIDTH)) |=> !in_ready_o)
    else $error("input taken while the window reloads");

  a_frame_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && fin) |=> ((col_q == '0) && (row_q == '0) && (flush_q == '0)))
    else $error("stream position not cleared at frame end");

endmodule

@@ tb/sv/tb_zero_padded_2d_convolution.sv @@
`timescale 1ns / 1ps

module tb_zero_padded_2d_convolution;

  localparam int FUNC_W  = zpc_pkg::FUNC_W;
  localparam int ACC_W   = zpc_pkg::ACC_W;
  localparam int CFG_AW  = zpc_pkg::CFG_AW;
  localparam int CFG_W   = zpc_pkg::CFG_W;
  localparam int PIX_W   = zpc_pkg::PIX_W;
  localparam int KPOS_W  = zpc_pkg::KPOS_W;
  localparam int COEFF_W = zpc_pkg::COEFF_W;

  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
  localparam int KDIM = 2 * zpc_pkg::MAX_HALF_Y + 1;
  localparam int RING_DEPTH =
    2 * (zpc_pkg::MAX_HALF_Y * zpc_pkg::MAX_WIDTH + zpc_pkg::MAX_HALF_X) + 1;
  localparam int CYCLE_LIMIT = 1_000_000;

  typedef struct {
    logic [ACC_W-1:0] value;
    bit               last;
  } conv_result_t;

  class conv_scoreboard;
    int unsigned width_reg, hx_reg, hy_reg;
    shortint kern[KDIM][KDIM];
    shortint ring[RING_DEPTH];
    int wpos, col, row;
    int unsigned nflush;
    conv_result_t expected_q[$];
    int errors, checked, items;

    function new();
      width_reg = 128;
      hx_reg = 1;
      hy_reg = 1;
      foreach (kern[i, j]) kern[i][j] = 0;
      foreach (ring[i]) ring[i] = 0;
      wpos = 0;
      col = 0;
      row = 0;
      nflush = 0;
    endfunction

    function void write_reg(logic [CFG_AW-1:0] idx, logic [CFG_W-1:0] data);
      if (idx == zpc_pkg::REG_IMAGE_WIDTH) width_reg = data;
      else if (idx == zpc_pkg::REG_HALF_X) hx_reg = data[1:0];
      else if (idx == zpc_pkg::REG_HALF_Y) hy_reg = data[1:0];
    endfunction

    function int eff_w();
      if (width_reg == 0) return 1;
      if (width_reg > zpc_pkg::MAX_WIDTH) return zpc_pkg::MAX_WIDTH;
      return width_reg;
    endfunction

    function int drain_len();
      return hy_reg * eff_w() + hx_reg;
    endfunction

    // Sum for the position hy rows and hx pixels behind the current sample.
    function bit window_sum(output longint acc);
      int w, hx, hy, tc, back, sr, sc, off, idx;
      w = eff_w();
      hx = hx_reg;
      hy = hy_reg;
      acc = 0;
      tc = col - hx;
      back = hy;
      while (tc < 0) begin
        tc += w;
        back++;
      end
      if (row < back) return 0;
      for (int ki = 0; ki <= 2 * hy; ki++) begin
        sr = back + ki - hy;
        if (sr < 0 || row < sr) continue;
        for (int kj = 0; kj <= 2 * hx; kj++) begin
          sc = tc - (kj - hx);
          if (sc < 0 || sc >= w) continue;
          off = sr * w + col - sc;
          if (off < 0 || off >= RING_DEPTH) continue;
          idx = wpos - off;
          if (idx < 0) idx += RING_DEPTH;
          acc += longint'(int'(kern[ki][kj]) * int'(ring[idx]));
        end
      end
      return 1;
    endfunction

    function void step_ring();
      wpos = (wpos + 1 >= RING_DEPTH) ? 0 : wpos + 1;
    endfunction

    function void end_frame();
      col = 0;
      row = 0;
      nflush = 0;
    endfunction

    function void note_input(logic [FUNC_W-1:0] f, logic [PIX_W-1:0] pix,
                             logic [KPOS_W-1:0] r, logic [KPOS_W-1:0] c,
                             logic [COEFF_W-1:0] v);
      longint acc;
      bit ok, fin;
      int dly;
      conv_result_t res;
      items++;
      if (f == zpc_pkg::FUNC_LOAD) begin
        if (r < KDIM && c < KDIM) kern[r][c] = v;
      end else if (f == zpc_pkg::FUNC_PIXEL) begin
        ring[wpos] = pix;
        nflush = 0;
        ok = window_sum(acc);
        step_ring();
        if (col + 1 >= eff_w()) begin
          col = 0;
          if (row < zpc_pkg::ROW_SAT) row++;
        end else begin
          col++;
        end
        if (ok) begin
          res.value = acc[ACC_W-1:0];
          res.last = 0;
          expected_q.push_back(res);
        end
      end else if (f == zpc_pkg::FUNC_FLUSH) begin
        dly = drain_len();
        if (dly == 0) begin
          end_frame();
        end else begin
          ring[wpos] = 0;
          nflush++;
          ok = window_sum(acc);
          fin = nflush >= dly;
          step_ring();
          if (fin) begin
            end_frame();
          end else if (col + 1 >= eff_w()) begin
            col = 0;
            if (row < zpc_pkg::ROW_SAT) row++;
          end else begin
            col++;
          end
          if (ok) begin
            res.value = acc[ACC_W-1:0];
            res.last = fin;
            expected_q.push_back(res);
          end
        end
      end
    endfunction

    function void check_result(logic [ACC_W-1:0] value, logic last);
      conv_result_t exp_r;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result value=%0d last=%0b", $time, $signed(value), last);
        errors++;
        return;
      end
      exp_r = expected_q.pop_front();
      checked++;
      if (exp_r.value !== value) begin
        $display("%0t: out_value mismatch expected=%0d actual=%0d", $time,
                 $signed(exp_r.value), $signed(value));
        errors++;
      end
      if (exp_r.last !== last) begin
        $display("%0t: last mismatch expected=%0b actual=%0b", $time, exp_r.last, last);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 0;
  logic rst_ni = 0;
  logic cfg_we_i = 0;
  logic [CFG_AW-1:0] cfg_addr_i = '0;
  logic [CFG_W-1:0] cfg_wdata_i = '0;
  logic in_valid_i = 0;
  logic in_ready_o;
  logic [FUNC_W-1:0] func_i = '0;
  logic signed [PIX_W-1:0] pixel_i = '0;
  logic [KPOS_W-1:0] coeff_row_i = '0;
  logic [KPOS_W-1:0] coeff_col_i = '0;
  logic signed [COEFF_W-1:0] coeff_value_i = '0;
  logic out_valid_o;
  logic out_ready_i = 0;
  logic signed [ACC_W-1:0] out_value_o;
  logic last_o;

  zero_padded_2d_convolution dut (.*);

  conv_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_left = 0;
  int cycles = 0;
  int frames = 0;

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb_zero_padded_2d_convolution: FAIL");
      $finish;
    end
  end

  // Receiver side: a long hold-off wins over random stalls.
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready_i <= 0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_result(out_value_o, last_o);
  end

  task automatic send_item(logic [FUNC_W-1:0] f, logic [PIX_W-1:0] pix,
                           logic [KPOS_W-1:0] r, logic [KPOS_W-1:0] c,
                           logic [COEFF_W-1:0] v);
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i <= 1;
    func_i <= f;
    pixel_i <= pix;
    coeff_row_i <= r;
    coeff_col_i <= c;
    coeff_value_i <= v;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_input(f, pix, r, c, v);
  endtask

  task automatic send_pixel(logic [PIX_W-1:0] pix);
    send_item(zpc_pkg::FUNC_PIXEL, pix, KPOS_W'($urandom), KPOS_W'($urandom),
              COEFF_W'($urandom));
  endtask

  task automatic send_flush();
    send_item(zpc_pkg::FUNC_FLUSH, PIX_W'($urandom), KPOS_W'($urandom), KPOS_W'($urandom),
              COEFF_W'($urandom));
  endtask

  // Loads and the unused code leave nothing in the queue, so allow the pipeline to settle.
  task automatic wait_drained();
    in_valid_i <= 0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_AW-1:0] idx, logic [CFG_W-1:0] data);
    cfg_we_i <= 1;
    cfg_addr_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    sb.write_reg(idx, data);
    cfg_we_i <= 0;
  endtask

  task automatic run_frame(int w_cfg, int hx, int hy, int nrows, int tail,
                           bit noisy, bit pause_mid);
    int n, nd, i;
    write_reg(zpc_pkg::REG_IMAGE_WIDTH, CFG_W'(w_cfg));
    write_reg(zpc_pkg::REG_HALF_X, CFG_W'((($urandom_range(0, 511)) << 2) | hx));
    write_reg(zpc_pkg::REG_HALF_Y, CFG_W'((($urandom_range(0, 511)) << 2) | hy));
    for (int r = 0; r <= 2 * hy; r++)
      for (int c = 0; c <= 2 * hx; c++)
        send_item(zpc_pkg::FUNC_LOAD, PIX_W'($urandom), KPOS_W'(r), KPOS_W'(c),
                  COEFF_W'($urandom));
    n = nrows * sb.eff_w() + tail;
    for (i = 0; i < n; i++) begin
      if (noisy && $urandom_range(19) == 0) begin
        if ($urandom_range(1))
          send_item(FUNC_UNUSED, PIX_W'($urandom), KPOS_W'($urandom), KPOS_W'($urandom),
                    COEFF_W'($urandom));
        else
          send_item(zpc_pkg::FUNC_LOAD, PIX_W'($urandom), 3'd7, KPOS_W'($urandom),
                    COEFF_W'($urandom));
      end
      if (pause_mid && i == n / 2) wait_drained();
      send_pixel(PIX_W'($urandom));
    end
    nd = sb.drain_len();
    if (nd == 0) begin
      send_flush();
    end else begin
      // A pixel in the middle of the drain restarts the flush count.
      i = 0;
      while (i < nd) begin
        if (noisy && $urandom_range(59) == 0) begin
          send_pixel(PIX_W'($urandom));
          i = 0;
        end else begin
          send_flush();
          i++;
        end
      end
    end
    wait_drained();
    frames++;
  endtask

  task automatic random_frame(bit noisy);
    int w, pick;
    pick = $urandom_range(9);
    if (pick == 0) begin
      w = $urandom_range(1) ? 1024 : 2047;
      run_frame(w, $urandom_range(3), 0, 0, $urandom_range(1, 40), noisy, 0);
    end else if (pick == 1) begin
      run_frame($urandom_range(1), $urandom_range(3), $urandom_range(3),
                0, $urandom_range(1, 12), noisy, 0);
    end else if (pick == 2) begin
      // Drain only, no pixels in the frame.
      run_frame($urandom_range(1, 10), $urandom_range(3), $urandom_range(3), 0, 0, noisy, 0);
    end else begin
      w = $urandom_range(1, 24);
      run_frame(w, $urandom_range(3), $urandom_range(3), $urandom_range(1, 5),
                $urandom_range(0, w - 1), noisy, 0);
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1;
    repeat (3) @(posedge clk_i);

    // Directed: coefficient and pixel extremes, ignored codes, zero-delay frame.
    write_reg(zpc_pkg::REG_IMAGE_WIDTH, CFG_W'(4));
    send_item(zpc_pkg::FUNC_LOAD, 16'h0000, 3'd6, 3'd6, 16'h7fff);
    send_item(zpc_pkg::FUNC_LOAD, 16'hffff, 3'd7, 3'd0, 16'h1234);
    send_item(zpc_pkg::FUNC_LOAD, 16'hffff, 3'd0, 3'd7, 16'h4321);
    send_item(FUNC_UNUSED, 16'h8000, 3'd5, 3'd5, 16'h8000);
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++)
        send_item(zpc_pkg::FUNC_LOAD, 16'h0, KPOS_W'(r), KPOS_W'(c),
                  (r + c) % 2 ? 16'h8000 : 16'h7fff);
    send_pixel(16'h8000);
    send_pixel(16'h7fff);
    send_pixel(16'h8000);
    send_pixel(16'hffff);
    send_pixel(16'h0001);
    repeat (5) send_flush();
    wait_drained();
    run_frame(3, 0, 0, 1, 0, 0, 0);
    run_frame(0, 3, 3, 0, 2, 0, 0);
    run_frame(2047, 3, 0, 0, 3, 0, 0);

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1 || ph == 3) ? (ph == 1 ? 75 : 18) : 0;
      recv_stall_pct = (ph == 2) ? 75 : (ph == 3 ? 18 : 0);
      if (ph == 0) begin
        hold_left = 300;
        run_frame(16, 2, 2, 4, 5, 0, 0);
        run_frame(12, 1, 2, 4, 3, 0, 1);
      end
      while (sb.items < 350 * (ph + 1) + 60) random_frame($urandom_range(3) == 0);
    end

    wait_drained();
    repeat (20) @(posedge clk_i);
    $display("Covered %0d frames and %0d transfers in; %0d results checked.",
             frames, sb.items, sb.checked);
    $display("Widths 0..2047, both halves 0..3, drains, pauses, stalls and long hold-off.");
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("tb_zero_padded_2d_convolution: PASS");
    end else begin
      $display("%0d errors, %0d results still expected", sb.errors, sb.expected_q.size());
      $display("tb_zero_padded_2d_convolution: FAIL");
    end
    $finish;
  end
endmodule
